FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the routing table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define ESR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked in every cycle, reset included.
`define ESR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/esr_pkg.sv
// Types, codes and sizes shared by the publish/subscribe routing table.
`default_nettype none

package esr_pkg;

    localparam int EVENT_SLOTS    = 16;
    localparam int SUBS_PER_EVENT = 8;
    localparam int SUB_ID_BITS    = 8;

    localparam int SLOT_W      = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int REG_CNT_W   = $clog2(EVENT_SLOTS + 1);
    localparam int SUB_IDX_W   = (SUBS_PER_EVENT > 1) ? $clog2(SUBS_PER_EVENT) : 1;
    localparam int CNT_W       = $clog2(SUBS_PER_EVENT + 1);
    localparam int LIST_DEPTH  = EVENT_SLOTS * SUBS_PER_EVENT;
    localparam int LIST_ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int SUB_W       = (SUB_ID_BITS < 8) ? SUB_ID_BITS : 8;

    localparam logic [1:0] CMD_REGISTER    = 2'd0;
    localparam logic [1:0] CMD_SUBSCRIBE   = 2'd1;
    localparam logic [1:0] CMD_UNSUBSCRIBE = 2'd2;
    localparam logic [1:0] CMD_PUBLISH     = 2'd3;

    localparam logic [1:0] STS_DONE    = 2'd0;
    localparam logic [1:0] STS_FAILED  = 2'd1;
    localparam logic [1:0] STS_DELIVER = 2'd2;
    localparam logic [1:0] STS_NO_DEL  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] evt_id;
        logic [7:0]  subscriber_id;
        logic [31:0] event_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  target_subscriber;
        logic [31:0] delivered_event;
        logic [31:0] delivered_data;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [31:0]      id;
    } t_tbl_ent;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  cnt;
        logic              full;
        logic [SLOT_W-1:0] free_slot;
    } t_tbl_stat;

endpackage

`default_nettype wire

FILE: hdl/esr_event_table.sv
// Event table memory of ids and list lengths, with its fill count and a sequential lookup engine.
`default_nettype none

module esr_event_table
    import esr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_reg_wr,
    input  wire logic              i_cnt_wr,
    input  wire logic [SLOT_W-1:0] i_cnt_slot,
    input  wire logic [CNT_W-1:0]  i_cnt_data,
    input  wire logic [31:0]       i_id,
    output t_tbl_stat              o_stat
);

    t_tbl_ent             mem_ents [EVENT_SLOTS];
    t_tbl_ent             r_q;
    logic                 r_q_vld;
    logic [SLOT_W-1:0]    r_q_idx;
    logic [REG_CNT_W-1:0] r_addr;
    logic [REG_CNT_W-1:0] r_reg_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_slot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 hit;
    logic                 rd_en;

    assign hit   = r_q_vld && (r_q.id == i_id);
    assign rd_en = r_busy && !i_start && !hit && (r_addr != r_reg_cnt);

    // One entry is read per cycle; its compare happens in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_q_vld   <= 1'b0;
            r_reg_cnt <= '0;
            r_addr    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_reg_wr) begin
                r_reg_cnt <= r_reg_cnt + 1'b1;
            end
            if (i_start) begin
                r_busy  <= 1'b1;
                r_addr  <= '0;
                r_q_vld <= 1'b0;
            end else if (r_busy) begin
                if (hit) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b1;
                    r_slot  <= r_q_idx;
                    r_cnt   <= r_q.cnt;
                    r_q_vld <= 1'b0;
                end else if (r_addr == r_reg_cnt) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b0;
                    r_slot  <= '0;
                    r_cnt   <= '0;
                    r_q_vld <= 1'b0;
                end else begin
                    r_q_vld <= 1'b1;
                    r_q_idx <= r_addr[SLOT_W-1:0];
                    r_addr  <= r_addr + 1'b1;
                end
            end
        end
    end

    // Each entry keeps the event id together with the length of its subscriber list.
    always_ff @(posedge i_clk) begin
        if (i_reg_wr) begin
            mem_ents[r_reg_cnt[SLOT_W-1:0]] <= {CNT_W'(0), i_id};
        end else if (i_cnt_wr) begin
            mem_ents[i_cnt_slot] <= {i_cnt_data, i_id};
        end
        if (rd_en) begin
            r_q <= mem_ents[r_addr[SLOT_W-1:0]];
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.found     = r_found;
    assign o_stat.slot      = r_slot;
    assign o_stat.cnt       = r_cnt;
    assign o_stat.full      = (r_reg_cnt == REG_CNT_W'(EVENT_SLOTS));
    assign o_stat.free_slot = r_reg_cnt[SLOT_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/event_subscription_router.sv
// Publish/subscribe routing table: sequencer and subscriber list memory.
// Lookup reads one event id per cycle and stops at the first match or after the last registered id.
// Register and subscribe act in S_EXEC, then give their single result from S_RESP.
// Unsubscribe scans the list once after the lookup, shifting later entries down as it goes.
// Publish sends one delivery word per cycle from the list memory unless the output stalls.
// Reset clears control state and the fill count only; the memories are not cleared.
`default_nettype none

module event_subscription_router
    import esr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_UNSUB  = 3'd3;
    localparam logic [2:0] S_PUB    = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [SUB_W-1:0] mem_list [LIST_DEPTH];

    logic [2:0]           r_state, n_state;
    t_in_item             r_item;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_slot;
    logic [SUB_IDX_W-1:0] r_k, n_k;
    logic                 r_hit, n_hit;
    logic [1:0]           r_status, n_status;
    logic [CNT_W-1:0]     r_cnt_q;
    logic [SUB_W-1:0]     r_list_q;
    logic                 r_o_valid;
    t_out_item            r_o_result;

    t_tbl_stat            tbl;
    logic                 tbl_start;
    logic                 tbl_reg_wr;
    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    t_out_item            out_next;
    logic                 k_last;
    logic                 match;
    logic [SUB_W-1:0]     sub_in;
    logic [LIST_ADDR_W-1:0] list_base;
    logic                 cnt_we;
    logic [CNT_W-1:0]     cnt_wdata;
    logic                 list_rd;
    logic [SUB_IDX_W-1:0] list_rk;
    logic                 list_we;
    logic [SUB_IDX_W-1:0] list_wk;
    logic [SUB_W-1:0]     list_wdata;

    esr_event_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (tbl_start),
        .i_reg_wr   (tbl_reg_wr),
        .i_cnt_wr   (cnt_we),
        .i_cnt_slot (r_slot),
        .i_cnt_data (cnt_wdata),
        .i_id       (r_state == S_IDLE ? i_item.evt_id : r_item.evt_id),
        .o_stat     (tbl)
    );

    assign accept    = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_o_valid || i_ready;
    assign k_last    = (CNT_W'(r_k) == r_cnt_q - 1'b1);
    assign sub_in    = r_item.subscriber_id[SUB_W-1:0];
    assign match     = (r_list_q == sub_in);
    assign list_base = LIST_ADDR_W'(r_slot) * LIST_ADDR_W'(SUBS_PER_EVENT);

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_hit      = r_hit;
        n_status   = r_status;
        tbl_start  = 1'b0;
        tbl_reg_wr = 1'b0;
        cnt_we     = 1'b0;
        cnt_wdata  = '0;
        list_rd    = 1'b0;
        list_rk    = '0;
        list_we    = 1'b0;
        list_wk    = '0;
        list_wdata = r_list_q;
        out_load   = 1'b0;
        out_next   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    tbl_start = 1'b1;
                    n_state   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (tbl.done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (r_item.cmd)
                    CMD_REGISTER: begin
                        if (!r_found && !tbl.full) begin
                            tbl_reg_wr = 1'b1;
                            n_status   = STS_DONE;
                        end else begin
                            n_status = STS_FAILED;
                        end
                    end
                    CMD_SUBSCRIBE: begin
                        if (r_found && (r_cnt_q < CNT_W'(SUBS_PER_EVENT))) begin
                            list_we    = 1'b1;
                            list_wk    = r_cnt_q[SUB_IDX_W-1:0];
                            list_wdata = sub_in;
                            cnt_we     = 1'b1;
                            cnt_wdata  = r_cnt_q + 1'b1;
                            n_status   = STS_DONE;
                        end else begin
                            n_status = STS_FAILED;
                        end
                    end
                    CMD_UNSUBSCRIBE: begin
                        if (r_found && (r_cnt_q != '0)) begin
                            list_rd = 1'b1;
                            n_k     = '0;
                            n_hit   = 1'b0;
                            n_state = S_UNSUB;
                        end else begin
                            n_status = STS_FAILED;
                        end
                    end
                    default: begin
                        if (r_found && (r_cnt_q != '0)) begin
                            list_rd = 1'b1;
                            n_k     = '0;
                            n_state = S_PUB;
                        end else begin
                            n_status = STS_NO_DEL;
                        end
                    end
                endcase
            end
            S_UNSUB: begin
                // After the first match every later entry moves down by one place.
                if (r_hit) begin
                    list_we = 1'b1;
                    list_wk = r_k - 1'b1;
                end
                n_hit = r_hit || match;
                if (k_last) begin
                    if (n_hit) begin
                        cnt_we    = 1'b1;
                        cnt_wdata = r_cnt_q - 1'b1;
                        n_status  = STS_DONE;
                    end else begin
                        n_status = STS_FAILED;
                    end
                    n_state = S_RESP;
                end else begin
                    list_rd = 1'b1;
                    list_rk = r_k + 1'b1;
                    n_k     = r_k + 1'b1;
                end
            end
            S_PUB: begin
                // The next entry is fetched only when this word leaves, so r_list_q holds.
                if (out_free) begin
                    out_load                   = 1'b1;
                    out_next.status            = STS_DELIVER;
                    out_next.target_subscriber = 8'(r_list_q);
                    out_next.delivered_event   = r_item.evt_id;
                    out_next.delivered_data    = r_item.event_data;
                    out_next.last              = k_last;
                    if (k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        list_rd = 1'b1;
                        list_rk = r_k + 1'b1;
                        n_k     = r_k + 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load                 = 1'b1;
                    out_next.status          = r_status;
                    out_next.delivered_event = r_item.evt_id;
                    out_next.last            = 1'b1;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_status <= n_status;
        if (accept) begin
            r_item <= i_item;
        end
        if (r_state == S_SEARCH && tbl.done) begin
            r_found <= tbl.found;
            r_slot  <= tbl.slot;
            r_cnt_q <= tbl.cnt;
        end
        if (out_load) begin
            r_o_result <= out_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (list_we) begin
            mem_list[list_base + LIST_ADDR_W'(list_wk)] <= list_wdata;
        end
        if (list_rd) begin
            r_list_q <= mem_list[list_base + LIST_ADDR_W'(list_rk)];
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;

endmodule

`default_nettype wire

FILE: hdl/esr_checker.sv
// Port-level checks for the routing table, attached to the top level by bind.
`default_nettype none

`include "assert_macros.svh"

module esr_checker
    import esr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_ready,
    input wire t_in_item  i_item,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_item o_result
);

    logic non_delivery;

    assign non_delivery = o_valid && (o_result.status != STS_DELIVER);

    `ESR_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "result word after reset")
    `ESR_ASSERT(a_one_item, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready, "second word taken while busy")
    `ESR_ASSERT(a_nondel_last, i_clk, i_rst_n, non_delivery |-> o_result.last, "status word without last")
    `ESR_ASSERT(a_nondel_zero, i_clk, i_rst_n, non_delivery |-> (o_result.target_subscriber == 8'd0) && (o_result.delivered_data == 32'd0), "status word carries delivery fields")
    `ESR_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_result), "stalled result changed")

endmodule

bind event_subscription_router esr_checker u_esr_checker (.*);

`default_nettype wire

FILE: dv/event_subscription_router_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the publish/subscribe routing table, with its own table predictor.
module event_subscription_router_tb;
    import esr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int POOL_SIZE    = 20;
    localparam int REPORT_LIMIT = 10;
    localparam logic [7:0] SUB_MASK = 8'((1 << SUB_W) - 1);

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_result;

    // Predicted routing table.
    logic [31:0] tbl_event [EVENT_SLOTS];
    int          tbl_count = 0;
    int          list_len  [EVENT_SLOTS];
    logic [7:0]  list_sub  [EVENT_SLOTS][SUBS_PER_EVENT];
    t_out_item   expected_results[$];

    logic [31:0] event_pool [POOL_SIZE];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_request   = 1'b0;
    logic        hold_active    = 1'b0;
    int          error_count    = 0;
    int          cycle_count    = 0;

    event_subscription_router u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    function automatic int find_slot(input logic [31:0] id);
        for (int s = 0; s < tbl_count; s++)
            if (tbl_event[s] == id) return s;
        return -1;
    endfunction

    // Applies one command word to the predicted table and queues the results it causes.
    function automatic void predict_routing(input t_in_item w);
        int         slot;
        int         hit;
        logic [7:0] sub;
        t_out_item  r;
        slot = find_slot(w.evt_id);
        sub  = w.subscriber_id & SUB_MASK;
        r = '0;
        r.delivered_event = w.evt_id;
        r.last   = 1'b1;
        r.status = STS_FAILED;
        case (w.cmd)
            CMD_REGISTER: begin
                if (slot < 0 && tbl_count < EVENT_SLOTS) begin
                    tbl_event[tbl_count] = w.evt_id;
                    list_len[tbl_count]  = 0;
                    tbl_count++;
                    r.status = STS_DONE;
                end
            end
            CMD_SUBSCRIBE: begin
                if (slot >= 0 && list_len[slot] < SUBS_PER_EVENT) begin
                    list_sub[slot][list_len[slot]] = sub;
                    list_len[slot]++;
                    r.status = STS_DONE;
                end
            end
            CMD_UNSUBSCRIBE: begin
                hit = -1;
                if (slot >= 0)
                    for (int k = list_len[slot] - 1; k >= 0; k--)
                        if (list_sub[slot][k] == sub) hit = k;
                if (hit >= 0) begin
                    for (int k = hit; k + 1 < list_len[slot]; k++)
                        list_sub[slot][k] = list_sub[slot][k + 1];
                    list_len[slot]--;
                    r.status = STS_DONE;
                end
            end
            CMD_PUBLISH: begin
                if (slot < 0 || list_len[slot] == 0) begin
                    r.status = STS_NO_DEL;
                end else begin
                    for (int k = 0; k < list_len[slot]; k++) begin
                        r.status            = STS_DELIVER;
                        r.target_subscriber = list_sub[slot][k];
                        r.delivered_data    = w.event_data;
                        r.last              = (k + 1 == list_len[slot]);
                        expected_results.push_back(r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        expected_results.push_back(r);
    endfunction

    // Offers one command word and waits until the block takes it.
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] id,
                             input logic [7:0] sub, input logic [31:0] data);
        t_in_item w;
        w.cmd           = cmd;
        w.evt_id        = id;
        w.subscriber_id = sub;
        w.event_data    = data;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= w;
        do @(posedge i_clk); while (!o_ready);
        predict_routing(w);
    endtask

    task automatic test_register;
        send_word(CMD_REGISTER, 32'h0000_0000, 8'($urandom), $urandom);
        send_word(CMD_REGISTER, 32'hFFFF_FFFF, 8'($urandom), $urandom);
        // A second register of a known id must fail.
        send_word(CMD_REGISTER, 32'h0000_0000, 8'($urandom), $urandom);
    endtask

    task automatic test_subscribe;
        send_word(CMD_SUBSCRIBE, 32'h0F0F_0F0F, 8'd9, $urandom);
        send_word(CMD_SUBSCRIBE, 32'hFFFF_FFFF, 8'd0, $urandom);
        send_word(CMD_SUBSCRIBE, 32'hFFFF_FFFF, 8'd255, $urandom);
        send_word(CMD_SUBSCRIBE, 32'hFFFF_FFFF, 8'd7, $urandom);
        send_word(CMD_SUBSCRIBE, 32'hFFFF_FFFF, 8'd7, $urandom);
        for (int k = 1; k <= 4; k++)
            send_word(CMD_SUBSCRIBE, 32'hFFFF_FFFF, 8'(k), $urandom);
        // The list is full now, so this one fails.
        send_word(CMD_SUBSCRIBE, 32'hFFFF_FFFF, 8'h55, $urandom);
        send_word(CMD_PUBLISH, 32'hFFFF_FFFF, 8'($urandom), 32'hFFFF_FFFF);
    endtask

    task automatic test_unsubscribe;
        send_word(CMD_UNSUBSCRIBE, 32'h1234_5678, 8'd7, $urandom);
        send_word(CMD_UNSUBSCRIBE, 32'hFFFF_FFFF, 8'd100, $urandom);
        send_word(CMD_UNSUBSCRIBE, 32'hFFFF_FFFF, 8'd7, $urandom);
        send_word(CMD_UNSUBSCRIBE, 32'hFFFF_FFFF, 8'd0, $urandom);
        send_word(CMD_UNSUBSCRIBE, 32'hFFFF_FFFF, 8'd4, $urandom);
        send_word(CMD_PUBLISH, 32'hFFFF_FFFF, 8'($urandom), 32'h0000_0000);
    endtask

    task automatic test_publish_empty;
        send_word(CMD_PUBLISH, 32'h0000_0000, 8'($urandom), $urandom);
        send_word(CMD_PUBLISH, 32'h0000_5A5A, 8'($urandom), $urandom);
    endtask

    // Fills every free slot, then tries one register too many.
    task automatic test_table_full;
        for (int k = 0; k < POOL_SIZE && tbl_count < EVENT_SLOTS; k++)
            if (find_slot(event_pool[k]) < 0)
                send_word(CMD_REGISTER, event_pool[k], 8'($urandom), $urandom);
        while (tbl_count < EVENT_SLOTS)
            send_word(CMD_REGISTER, $urandom, 8'($urandom), $urandom);
        send_word(CMD_REGISTER, $urandom, 8'($urandom), $urandom);
    endtask

    task automatic test_random_traffic(input int n_words, input int idle_pct,
                                       input int stall_pct);
        int          pick;
        int          slot;
        logic [1:0]  cmd;
        logic [31:0] id;
        logic [7:0]  sub;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_words) begin
            pick = $urandom_range(99);
            if (pick < 10)      cmd = CMD_REGISTER;
            else if (pick < 45) cmd = CMD_SUBSCRIBE;
            else if (pick < 65) cmd = CMD_UNSUBSCRIBE;
            else                cmd = CMD_PUBLISH;
            id  = ($urandom_range(9) == 0) ? $urandom : event_pool[$urandom_range(POOL_SIZE - 1)];
            sub = ($urandom_range(9) < 7) ? 8'($urandom_range(15)) : 8'($urandom);
            slot = find_slot(id);
            // Most removals name a subscriber that is really on the list.
            if (cmd == CMD_UNSUBSCRIBE && slot >= 0 && list_len[slot] > 0
                && $urandom_range(9) < 7)
                sub = list_sub[slot][$urandom_range(list_len[slot] - 1)];
            send_word(cmd, id, sub, $urandom);
        end
    endtask

    // Publishes keep coming while the receiver holds off, so the block has to stall its input.
    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (int k = 0; k < 16; k++)
            send_word(CMD_PUBLISH, tbl_event[k % tbl_count], 8'($urandom), $urandom);
    endtask

    initial begin : receiver_hold
        forever begin
            wait (hold_request);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active  <= 1'b0;
            hold_request  = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result word: status %0d sub %0d event %h data %h last %0d",
                             o_result.status, o_result.target_subscriber,
                             o_result.delivered_event, o_result.delivered_data, o_result.last);
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status
                    || o_result.target_subscriber !== want.target_subscriber
                    || o_result.delivered_event !== want.delivered_event
                    || o_result.delivered_data !== want.delivered_data
                    || o_result.last !== want.last) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("mismatch: expected status %0d sub %0d event %h data %h last %0d",
                                 want.status, want.target_subscriber, want.delivered_event,
                                 want.delivered_data, want.last);
                        $display("          actual   status %0d sub %0d event %h data %h last %0d",
                                 o_result.status, o_result.target_subscriber,
                                 o_result.delivered_event, o_result.delivered_data,
                                 o_result.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        event_pool[0] = 32'h0000_0000;
        event_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < POOL_SIZE; k++)
            event_pool[k] = $urandom;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register();
        test_subscribe();
        test_unsubscribe();
        test_publish_empty();
        test_random_traffic(115, 0, 0);
        test_table_full();
        test_random_traffic(115, 63, 0);
        test_random_traffic(115, 0, 63);
        test_backpressure();
        test_random_traffic(115, 29, 29);

        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/esr_pkg.sv
hdl/esr_event_table.sv
hdl/event_subscription_router.sv
hdl/esr_checker.sv
dv/event_subscription_router_tb.sv
